[rtl/wasm_section_walker_macros.svh]
// assertion macros for the wasm section walker
// used by the top level only, no other dependencies
`ifndef WASM_SECTION_WALKER_MACROS_SVH
`define WASM_SECTION_WALKER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define WSW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wasm_section_walker: assertion failed");

`define WSW_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("wasm_section_walker: assertion failed");

`else

`define WSW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define WSW_ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

[rtl/wsw_pkg.sv]
// types and constants shared by the wasm section walker modules
// no dependencies
package wsw_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_module;
  } wsw_in_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  id_byte;
    logic [31:0] body_offset;
    logic [31:0] body_length;
    logic [15:0] section_count;
    logic [1:0]  status;
    logic        last_result;
  } wsw_out_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } wsw_push_t;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_ID,
    PH_SIZE
  } wsw_phase_t;

  localparam logic        REC_HEADER = 1'b0;
  localparam logic        REC_END    = 1'b1;

  localparam logic [1:0]  ST_OK        = 2'd0;
  localparam logic [1:0]  ST_TRUNCATED = 2'd1;
  localparam logic [1:0]  ST_TOO_LONG  = 2'd2;

  localparam logic [31:0] HEADER_SKIP  = 32'd8;
  localparam logic [2:0]  MAX_GROUPS   = 3'd5;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  localparam int          FIFO_DEPTH   = 4;
  localparam int          FIFO_AW      = 2;
  localparam int          FIFO_LW      = 3;

  // place one leb128 group at bit 7*grp, bits past 31 dropped
  function automatic logic [31:0] size_bits(input logic [7:0] b, input logic [2:0] grp);
    logic [31:0] r;
    unique case (grp)
      3'd0:    r = {25'd0, b[6:0]};
      3'd1:    r = {18'd0, b[6:0], 7'd0};
      3'd2:    r = {11'd0, b[6:0], 14'd0};
      3'd3:    r = {4'd0, b[6:0], 21'd0};
      3'd4:    r = {b[3:0], 28'd0};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/wsw_parser.sv]
// section walker state machine: consumes one byte per item, builds records
// depends on wsw_pkg
module wsw_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  wsw_pkg::wsw_in_t  in_item,
  output wsw_pkg::wsw_push_t push,
  output wsw_pkg::wsw_out_t rec0,
  output wsw_pkg::wsw_out_t rec1
);
  import wsw_pkg::*;

  wsw_phase_t  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  grp_r, grp_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic        err_r, err_nxt;

  logic        hdr_done;
  wsw_out_t    hdr_rec;
  wsw_out_t    end_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      pos_r   <= '0;
      skip_r  <= HEADER_SKIP;
      id_r    <= '0;
      acc_r   <= '0;
      grp_r   <= '0;
      seen_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      id_r    <= id_nxt;
      acc_r   <= acc_nxt;
      grp_r   <= grp_nxt;
      seen_r  <= seen_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    skip_nxt  = skip_r;
    id_nxt    = id_r;
    acc_nxt   = acc_r;
    grp_nxt   = grp_r;
    seen_nxt  = seen_r;
    err_nxt   = err_r;
    hdr_done  = 1'b0;
    hdr_rec   = '0;
    end_rec   = '0;
    push      = '0;
    rec0      = '0;
    rec1      = '0;

    if (accept) begin
      pos_nxt = pos_r + 32'd1;
      unique case (phase_r)
        PH_SKIP: begin
          if (skip_r <= 32'd1) begin
            skip_nxt  = '0;
            phase_nxt = PH_ID;
          end else begin
            skip_nxt = skip_r - 32'd1;
          end
        end
        PH_ID: begin
          id_nxt    = in_item.data_byte;
          acc_nxt   = '0;
          grp_nxt   = '0;
          err_nxt   = 1'b0;
          phase_nxt = PH_SIZE;
        end
        PH_SIZE: begin
          if (grp_r < MAX_GROUPS) begin
            acc_nxt = acc_r | size_bits(in_item.data_byte, grp_r);
            grp_nxt = grp_r + 3'd1;
          end else begin
            err_nxt = 1'b1;
          end
          if (!in_item.data_byte[7]) begin
            hdr_done = 1'b1;
            if (seen_r != COUNT_MAX) begin
              seen_nxt = seen_r + 16'd1;
            end
            if (acc_nxt == 32'd0) begin
              phase_nxt = PH_ID;
            end else begin
              phase_nxt = PH_SKIP;
              skip_nxt  = acc_nxt;
            end
          end
        end
        default: begin
          phase_nxt = PH_SKIP;
        end
      endcase

      hdr_rec.record_kind   = REC_HEADER;
      hdr_rec.id_byte       = id_r;
      hdr_rec.body_offset   = pos_nxt;
      hdr_rec.body_length   = acc_nxt;
      hdr_rec.section_count = seen_nxt;
      hdr_rec.status        = err_nxt ? ST_TOO_LONG : ST_OK;
      hdr_rec.last_result   = !in_item.end_of_module;

      end_rec.record_kind   = REC_END;
      end_rec.id_byte       = '0;
      end_rec.body_offset   = pos_nxt;
      end_rec.body_length   = '0;
      end_rec.section_count = seen_nxt;
      end_rec.status        = (phase_nxt == PH_SIZE) ? ST_TRUNCATED : ST_OK;
      end_rec.last_result   = 1'b1;

      if (hdr_done) begin
        push.push0 = 1'b1;
        rec0       = hdr_rec;
        if (in_item.end_of_module) begin
          push.push1 = 1'b1;
          rec1       = end_rec;
        end
      end else if (in_item.end_of_module) begin
        push.push0 = 1'b1;
        rec0       = end_rec;
      end

      // start over for the next module
      if (in_item.end_of_module) begin
        phase_nxt = PH_SKIP;
        pos_nxt   = '0;
        skip_nxt  = HEADER_SKIP;
        id_nxt    = '0;
        acc_nxt   = '0;
        grp_nxt   = '0;
        seen_nxt  = '0;
        err_nxt   = 1'b0;
      end
    end
  end

endmodule

[rtl/wsw_result_fifo.sv]
// result queue: takes up to two records per cycle, hands out one per cycle while out_stall is low
// depends on wsw_pkg
module wsw_result_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wsw_pkg::wsw_push_t        push,
  input  wsw_pkg::wsw_out_t         rec0,
  input  wsw_pkg::wsw_out_t         rec1,
  output logic                      out_valid,
  input  logic                      out_stall,
  output wsw_pkg::wsw_out_t         out_data,
  output logic [wsw_pkg::FIFO_LW-1:0] level
);
  import wsw_pkg::*;

  wsw_out_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_r, wr_nxt;
  logic [FIFO_AW-1:0]   rd_r, rd_nxt;
  logic [FIFO_LW-1:0]   level_r, level_nxt;
  logic [FIFO_AW-1:0]   wr_plus1;
  logic                 pop;

  assign out_valid = (level_r != '0);
  assign out_data  = mem_r[rd_r];
  assign level     = level_r;
  assign pop       = out_valid && !out_stall;
  assign wr_plus1  = wr_r + FIFO_AW'(1);

  always_comb begin
    wr_nxt    = wr_r + FIFO_AW'(push.push0) + FIFO_AW'(push.push1);
    rd_nxt    = rd_r + FIFO_AW'(pop);
    level_nxt = level_r + FIFO_LW'(push.push0) + FIFO_LW'(push.push1) - FIFO_LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_r] <= rec0;
    end
    if (push.push1) begin
      mem_r[wr_plus1] <= rec1;
    end
  end

endmodule

[rtl/wasm_section_walker.sv]
// wasm section walker top level: byte parser feeding a small result queue
// depends on wsw_pkg, wsw_parser, wsw_result_fifo, wasm_section_walker_macros.svh
//
// usage
//   input channel: one module byte per item (in_data.data_byte), with
//   in_data.end_of_module set on the final byte of a module image
//   output channel: one record per item, section header records and one
//   end of module record per image, in byte order
//   a record is offered on out_valid in the cycle after the byte that
//   causes it is taken, when the result queue is empty
//   throughput: one byte per cycle while in_stall is low; the four-entry
//   result queue drains one record per cycle while out_stall is low, and
//   in_stall rises while it holds more than two records
//   reset: synchronous, active low; the walker returns to skipping the
//   eight-byte preamble and the queue empties
//   receiver stall: out_data holds while out_stall is high; the queue fills
//   and then stalls the input side
`include "wasm_section_walker_macros.svh"

module wasm_section_walker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wsw_pkg::wsw_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wsw_pkg::wsw_out_t out_data
);
  import wsw_pkg::*;

  logic               accept;
  wsw_push_t          push;
  wsw_out_t           rec0;
  wsw_out_t           rec1;
  logic [FIFO_LW-1:0] level;

  assign in_stall = (level > FIFO_LW'(FIFO_DEPTH - 2));
  assign accept   = in_valid && !in_stall;

  wsw_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .push    (push),
    .rec0    (rec0),
    .rec1    (rec1)
  );

  wsw_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .rec0      (rec0),
    .rec1      (rec1),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .level     (level)
  );

  `WSW_ASSERT_ALWAYS(a_level_bound, clk, rst_n, level <= FIFO_LW'(FIFO_DEPTH))
  `WSW_ASSERT_IMPLIES(a_end_pushes, clk, rst_n, accept && in_data.end_of_module, push.push0)
  `WSW_ASSERT_IMPLIES(a_second_after_first, clk, rst_n, push.push1, push.push0 && accept)
  `WSW_ASSERT_IMPLIES(a_end_is_last, clk, rst_n, out_valid && out_data.record_kind == REC_END, out_data.last_result)

endmodule

[tb/wasm_section_walker_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for wasm_section_walker: streams module images byte by byte
// and checks every record against a section walk kept in the bench
// depends on wsw_pkg and the wasm_section_walker rtl
module wasm_section_walker_tb;
  import wsw_pkg::*;

  localparam logic [63:0] WASM_PREAMBLE = 64'h0061736D_01000000;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  wsw_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  wsw_out_t out_data;

  wasm_section_walker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  wsw_in_t     byte_feed[$];
  wsw_out_t    expected_records[$];
  logic [7:0]  image_bytes[$];
  wsw_out_t    wanted;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_request = 0;
  int          holds_taken = 0;
  int          hold_left = 0;
  int          mismatches = 0;

  // section walk state
  wsw_phase_t  walk_phase = PH_SKIP;
  logic [31:0] walk_pos = '0;
  logic [31:0] skip_left = HEADER_SKIP;
  logic [7:0]  cur_id = '0;
  logic [31:0] size_acc = '0;
  logic [2:0]  group_cnt = '0;
  logic [15:0] sections_seen = '0;
  logic        size_too_long = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task reset_walk();
    walk_phase = PH_SKIP;
    walk_pos = '0;
    skip_left = HEADER_SKIP;
    cur_id = '0;
    size_acc = '0;
    group_cnt = '0;
    sections_seen = '0;
    size_too_long = 1'b0;
  endtask

  task automatic walk_byte(input wsw_in_t b);
    wsw_out_t rec;
    rec = '0;
    walk_pos = walk_pos + 32'd1;
    case (walk_phase)
      PH_SKIP: begin
        if (skip_left <= 32'd1) begin
          skip_left = '0;
          walk_phase = PH_ID;
        end else begin
          skip_left = skip_left - 32'd1;
        end
      end
      PH_ID: begin
        cur_id = b.data_byte;
        size_acc = '0;
        group_cnt = '0;
        size_too_long = 1'b0;
        walk_phase = PH_SIZE;
      end
      default: begin
        if (group_cnt < MAX_GROUPS) begin
          size_acc = size_acc | ({25'd0, b.data_byte[6:0]} << (7 * group_cnt));
          group_cnt = group_cnt + 3'd1;
        end else begin
          size_too_long = 1'b1;
        end
        if (!b.data_byte[7]) begin
          if (sections_seen != COUNT_MAX) sections_seen = sections_seen + 16'd1;
          rec.record_kind = REC_HEADER;
          rec.id_byte = cur_id;
          rec.body_offset = walk_pos;
          rec.body_length = size_acc;
          rec.section_count = sections_seen;
          rec.status = size_too_long ? ST_TOO_LONG : ST_OK;
          rec.last_result = !b.end_of_module;
          expected_records.push_back(rec);
          if (size_acc == '0) begin
            walk_phase = PH_ID;
          end else begin
            walk_phase = PH_SKIP;
            skip_left = size_acc;
          end
        end
      end
    endcase
    if (b.end_of_module) begin
      rec = '0;
      rec.record_kind = REC_END;
      rec.body_offset = walk_pos;
      rec.section_count = sections_seen;
      rec.status = (walk_phase == PH_SIZE) ? ST_TRUNCATED : ST_OK;
      rec.last_result = 1'b1;
      expected_records.push_back(rec);
      reset_walk();
    end
  endtask

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, exp_val);
  endtask

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      reset_walk();
    end else begin
      if (in_valid && !in_stall) walk_byte(in_data);
      if (!in_valid || !in_stall) begin
        if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= byte_feed.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_request != holds_taken) begin
      holds_taken <= hold_request;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // record monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_records.size() == 0) begin
        report_mismatch("record with none expected", out_data.body_offset, 32'd0);
      end else begin
        wanted = expected_records.pop_front();
        if (out_data.record_kind !== wanted.record_kind)
          report_mismatch("record_kind", 32'(out_data.record_kind),
                          32'(wanted.record_kind));
        if (out_data.id_byte !== wanted.id_byte)
          report_mismatch("id_byte", 32'(out_data.id_byte), 32'(wanted.id_byte));
        if (out_data.body_offset !== wanted.body_offset)
          report_mismatch("body_offset", out_data.body_offset, wanted.body_offset);
        if (out_data.body_length !== wanted.body_length)
          report_mismatch("body_length", out_data.body_length, wanted.body_length);
        if (out_data.section_count !== wanted.section_count)
          report_mismatch("section_count", 32'(out_data.section_count),
                          32'(wanted.section_count));
        if (out_data.status !== wanted.status)
          report_mismatch("status", 32'(out_data.status), 32'(wanted.status));
        if (out_data.last_result !== wanted.last_result)
          report_mismatch("last_result", 32'(out_data.last_result),
                          32'(wanted.last_result));
      end
    end
  end

  task add_preamble(input bit scrambled);
    logic [31:0] rnd;
    for (int k = 0; k < 8; k++) begin
      rnd = $urandom;
      image_bytes.push_back(scrambled ? rnd[7:0] : WASM_PREAMBLE[63 - 8 * k -: 8]);
    end
  endtask

  task add_size_field(input logic [31:0] value, input int pad_groups);
    logic [31:0] rest;
    logic [7:0]  grp;
    bit          more;
    rest = value;
    more = 1'b1;
    while (more) begin
      grp = {1'b0, rest[6:0]};
      rest = rest >> 7;
      more = (rest != 0);
      if (more || pad_groups > 0) grp[7] = 1'b1;
      image_bytes.push_back(grp);
    end
    for (int k = 0; k < pad_groups; k++)
      image_bytes.push_back((k == pad_groups - 1) ? 8'h00 : 8'h80);
  endtask

  task queue_image(input int keep);
    wsw_in_t next_byte;
    for (int k = 0; k < keep; k++) begin
      next_byte.data_byte = image_bytes[k];
      next_byte.end_of_module = (k == keep - 1);
      byte_feed.push_back(next_byte);
    end
    image_bytes.delete();
  endtask

  task build_random_module();
    int          nsec;
    int          pick;
    int          pad;
    int          keep;
    bit          huge;
    logic [31:0] rnd;
    logic [31:0] body_len;
    add_preamble($urandom_range(0, 3) == 0);
    nsec = $urandom_range(0, 6);
    huge = 1'b0;
    for (int s = 0; s < nsec && !huge; s++) begin
      rnd = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 12);
      image_bytes.push_back(rnd[7:0]);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        body_len = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom;
        huge = 1'b1;
      end else if (pick < 4) begin
        body_len = '0;
      end else begin
        body_len = $urandom_range(1, 10);
      end
      if ($urandom_range(0, 9) == 0) pad = $urandom_range(4, 6);
      else if ($urandom_range(0, 4) == 0) pad = $urandom_range(1, 3);
      else pad = 0;
      add_size_field(body_len, pad);
      if (!huge) begin
        for (int k = 0; k < body_len; k++) begin
          rnd = $urandom;
          image_bytes.push_back(rnd[7:0]);
        end
      end
    end
    keep = image_bytes.size();
    if ($urandom_range(0, 4) == 0) keep = $urandom_range(1, keep);
    queue_image(keep);
  endtask

  task add_noise();
    wsw_in_t     next_byte;
    logic [31:0] rnd;
    int          n;
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      rnd = $urandom;
      next_byte.data_byte = rnd[7:0];
      next_byte.end_of_module = (k == n - 1) || ($urandom_range(0, 5) == 0);
      byte_feed.push_back(next_byte);
    end
  endtask

  task drain();
    while (byte_feed.size() != 0 || in_valid || expected_records.size() != 0)
      @(negedge clk);
  endtask

  task run_random_phase(input int send_pct, input int recv_pct, input int n_bytes,
                        input bit with_hold);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    while (byte_feed.size() < n_bytes) begin
      if ($urandom_range(0, 9) == 0) add_noise();
      else build_random_module();
    end
    if (with_hold) hold_request = hold_request + 1;
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // zero length body, overlong size, fifth group high bits, header closed on last byte
    add_preamble(1'b0);
    image_bytes.push_back(8'h00);
    image_bytes.push_back(8'h00);
    image_bytes.push_back(8'hFF);
    add_size_field(32'd0, 5);
    image_bytes.push_back(8'h0B);
    for (int k = 0; k < 4; k++) image_bytes.push_back(8'hFF);
    image_bytes.push_back(8'h7F);
    queue_image(image_bytes.size());
    drain();

    run_random_phase(0, 0, 330, 1'b1);
    run_random_phase(80, 0, 330, 1'b0);
    run_random_phase(0, 80, 330, 1'b0);
    run_random_phase(21, 21, 330, 1'b0);

    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
